>>> hdl/sac_pkg.sv
package sac_pkg;

    // Base of the return stack and limit of the data stack
    localparam int MIDDLE_ADDRESS = 100;

    // Saturation bounds of the accumulator and of stack arithmetic
    localparam logic signed [23:0] SAT_HI = 24'sd999;
    localparam logic signed [23:0] SAT_LO = -24'sd999;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_STACK  = 2'd1,
        ERR_OPCODE = 2'd2,
        ERR_FETCH  = 2'd3
    } err_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic load;
        logic fetch;
        logic latch_ins;
        logic rd_a;
        logic rd_b;
        logic cap_a;
        logic exec;
        logic div_start;
        logic div_load;
        logic wr1;
        logic wr2;
        logic resp_load;
        logic set_fault;
        err_t fault_code;
    } sac_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic in_mode;
        logic halted;
        logic pc_bad;
        logic dec_fault;
        err_t dec_err;
        logic is_div;
        logic div_zero;
        logic div_done;
        logic has_wr1;
        logic has_wr2;
    } sac_sts_t;

    function automatic logic signed [23:0] sx24(input logic signed [10:0] v);
        return {{13{v[10]}}, v};
    endfunction

    function automatic logic signed [10:0] cap999(input logic signed [23:0] v);
        logic signed [10:0] r;
        if (v > SAT_HI)
            r = 11'sd999;
        else if (v < SAT_LO)
            r = -11'sd999;
        else
            r = v[10:0];
        return r;
    endfunction

endpackage

>>> hdl/stack_accumulator_cpu_core_top.sv
// Sequential core: one request at a time, through a single-port program memory.
// Load writes one word; a step fetches, decodes, reads operands A and B, executes,
// then writes memory where needed (twice for SWAP); SDIV waits on the bit-serial
// divider; fetch/stack faults end early. The next request can be taken once the result is presented.
// Reset is asynchronous, active low; afterwards a clearing pass zeroes memory,
// one word at a time, with in_stall high.
module stack_accumulator_cpu_core_top
    import sac_pkg::*;
#(
    parameter int TOP_ADDRESS = 199
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [7:0]         address,
    input  logic signed [10:0] word_value,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               out_valid,
    output logic signed [10:0] out_value,
    output logic               halted,
    output logic [1:0]         error_kind,
    output logic signed [10:0] pc_now,
    output logic signed [10:0] acc_now
);

    sac_cmd_t cmd;
    sac_sts_t sts;

    sac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sac_dp #(
        .TOP_ADDRESS (TOP_ADDRESS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .mode       (mode),
        .address    (address),
        .word_value (word_value),
        .out_valid  (out_valid),
        .out_value  (out_value),
        .halted     (halted),
        .error_kind (error_kind),
        .pc_now     (pc_now),
        .acc_now    (acc_now)
    );

endmodule

>>> hdl/sac_div.sv
module sac_div
    import sac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [10:0] dividend,
    input  logic signed [10:0] divisor,
    output logic               done,
    output logic signed [11:0] quotient
);

    localparam int DIV_STEPS = 11;

    logic        run_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [10:0] rem_reg;
    logic [10:0] quo_reg;
    logic [10:0] dvs_reg;
    logic        neg_reg;

    logic [10:0] shifted;
    logic [11:0] diff;
    logic        ge;

    // One restoring step per cycle on magnitudes
    assign shifted = {rem_reg[9:0], quo_reg[10]};
    assign diff    = {1'b0, shifted} - {1'b0, dvs_reg};
    assign ge      = ~diff[11];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[10] ? 11'(-dividend) : dividend;
            dvs_reg <= divisor[10] ? 11'(-divisor) : divisor;
            neg_reg <= dividend[10] ^ divisor[10];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[10:0] : shifted;
            quo_reg <= {quo_reg[9:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

>>> hdl/sac_dp.sv
module sac_dp
    import sac_pkg::*;
#(
    parameter int TOP_ADDRESS = 199
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sac_cmd_t           cmd,
    output sac_sts_t           sts,
    input  logic               mode,
    input  logic [7:0]         address,
    input  logic signed [10:0] word_value,
    output logic               out_valid,
    output logic signed [10:0] out_value,
    output logic               halted,
    output logic [1:0]         error_kind,
    output logic signed [10:0] pc_now,
    output logic signed [10:0] acc_now
);

    localparam int AW  = $clog2(TOP_ADDRESS + 1);
    localparam int SPW = $clog2(TOP_ADDRESS + 2);
    localparam int CW  = (SPW + 3 > 12) ? SPW + 3 : 12;

    localparam logic signed [CW-1:0] TOP_C  = CW'(TOP_ADDRESS);
    localparam logic signed [CW-1:0] TOP1_C = CW'(TOP_ADDRESS + 1);
    localparam logic signed [CW-1:0] MID_C  = CW'(MIDDLE_ADDRESS);
    localparam logic signed [CW-1:0] ONE_C  = CW'(1);
    localparam logic signed [CW-1:0] SPSUB_BIAS = CW'(100);
    localparam logic signed [CW-1:0] SLDA_BIAS  = CW'(201);
    localparam logic signed [CW-1:0] SSTA_BIAS  = CW'(400);

    // Opcodes and opcode range bases
    localparam logic signed [10:0] OPC_HLT   = 11'sd0;
    localparam logic signed [10:0] BASE_ADD  = 11'sd100;
    localparam logic signed [10:0] BASE_SUB  = 11'sd200;
    localparam logic signed [10:0] BASE_STA  = 11'sd300;
    localparam logic signed [10:0] BASE_LDI  = 11'sd400;
    localparam logic signed [10:0] BASE_LDA  = 11'sd500;
    localparam logic signed [10:0] BASE_BRA  = 11'sd600;
    localparam logic signed [10:0] BASE_BRZ  = 11'sd700;
    localparam logic signed [10:0] BASE_BRP  = 11'sd800;
    localparam logic signed [10:0] BASE_END  = 11'sd900;
    localparam logic signed [10:0] OPC_INP   = 11'sd901;
    localparam logic signed [10:0] OPC_OUT   = 11'sd902;
    localparam logic signed [10:0] OPC_JAL   = 11'sd910;
    localparam logic signed [10:0] OPC_RET   = 11'sd911;
    localparam logic signed [10:0] OPC_PUSH  = 11'sd920;
    localparam logic signed [10:0] OPC_POP   = 11'sd921;
    localparam logic signed [10:0] OPC_DUP   = 11'sd922;
    localparam logic signed [10:0] OPC_DROP  = 11'sd923;
    localparam logic signed [10:0] OPC_SWAP  = 11'sd924;
    localparam logic signed [10:0] OPC_RPUSH = 11'sd925;
    localparam logic signed [10:0] OPC_RPOP  = 11'sd926;
    localparam logic signed [10:0] OPC_SADD  = 11'sd930;
    localparam logic signed [10:0] OPC_SSUB  = 11'sd931;
    localparam logic signed [10:0] OPC_SMUL  = 11'sd932;
    localparam logic signed [10:0] OPC_SDIV  = 11'sd933;
    localparam logic signed [10:0] OPC_SMAX  = 11'sd934;
    localparam logic signed [10:0] OPC_SMIN  = 11'sd935;
    localparam logic signed [10:0] OPC_SGT   = 11'sd937;
    localparam logic signed [10:0] OPC_SLT   = 11'sd938;
    localparam logic signed [10:0] OPC_SNOT  = 11'sd939;
    localparam logic signed [10:0] SPADD_LO  = -11'sd99;
    localparam logic signed [10:0] SPADD_HI  = -11'sd1;
    localparam logic signed [10:0] SPSUB_LO  = -11'sd199;
    localparam logic signed [10:0] SPSUB_HI  = -11'sd100;
    localparam logic signed [10:0] SLDA_LO   = -11'sd299;
    localparam logic signed [10:0] SLDA_HI   = -11'sd200;
    localparam logic signed [10:0] SSTA_LO   = -11'sd500;
    localparam logic signed [10:0] SSTA_HI   = -11'sd401;

    typedef enum logic [5:0] {
        OP_BAD, OP_HLT, OP_ADD, OP_SUB, OP_STA, OP_LDI, OP_LDA, OP_BRA, OP_BRZ,
        OP_BRP, OP_INP, OP_OUT, OP_JAL, OP_RET, OP_PUSH, OP_POP, OP_DUP, OP_DROP,
        OP_SWAP, OP_RPUSH, OP_RPOP, OP_SADD, OP_SSUB, OP_SMUL, OP_SDIV, OP_SMAX,
        OP_SMIN, OP_SGT, OP_SLT, OP_SNOT, OP_SPADD, OP_SPSUB, OP_SLDA, OP_SSTA
    } op_t;

    // Architectural state
    logic signed [10:0] acc_reg, pc_reg, ret_reg;
    logic [SPW-1:0]     sp_reg, rsp_reg;
    logic               halted_reg;
    err_t               fault_reg;
    logic [AW-1:0]      clr_reg;

    // Per-request working registers
    logic [7:0]         addr_reg;
    logic signed [10:0] word_reg;
    logic signed [10:0] ins_reg;
    logic signed [10:0] a_reg;
    logic signed [10:0] res_reg;
    logic [AW-1:0]      wad_reg;
    logic               emit_reg;

    // Result registers
    logic               o_valid_reg;
    logic signed [10:0] o_value_reg;
    logic               o_halted_reg;
    err_t               o_err_reg;
    logic signed [10:0] o_pc_reg;
    logic signed [10:0] o_acc_reg;

    // Program memory, one port
    logic signed [10:0] mem [0:TOP_ADDRESS];
    logic signed [10:0] mem_rdata;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_addr;
    logic signed [10:0] mem_wdata;

    op_t                op;
    logic [6:0]         xx;
    logic signed [CW-1:0] ins_c, sp_c, rsp_c, xx_c;
    logic signed [CW-1:0] n_spadd, n_spsub, idx_slda, idx_ssta;
    logic signed [CW-1:0] load_c;
    logic               dec_fault;
    err_t               dec_err;
    logic [AW-1:0]      rda, rdb;

    logic signed [10:0] b_val;
    logic signed [21:0] prod;
    logic signed [10:0] bin_r;

    logic signed [10:0] acc_x, pc_x, ret_x, res_x;
    logic signed [CW-1:0] sp_x, rsp_x, wad_x;
    logic               emit_x, hlt_x;

    logic               div_done;
    logic signed [11:0] div_q;

    function automatic logic [AW-1:0] to_idx(input logic signed [CW-1:0] v);
        logic [AW-1:0] r;
        if (v < 0 || v > TOP_C)
            r = '0;
        else
            r = v[AW-1:0];
        return r;
    endfunction

    assign ins_c  = {{(CW-11){ins_reg[10]}}, ins_reg};
    assign sp_c   = $signed({{(CW-SPW){1'b0}}, sp_reg});
    assign rsp_c  = $signed({{(CW-SPW){1'b0}}, rsp_reg});
    assign xx_c   = $signed({{(CW-7){1'b0}}, xx});
    assign load_c = $signed({{(CW-8){1'b0}}, addr_reg});

    assign n_spadd  = sp_c - ins_c;
    assign n_spsub  = sp_c + ins_c + SPSUB_BIAS;
    assign idx_slda = sp_c - ins_c - SLDA_BIAS;
    assign idx_ssta = sp_c - ins_c - SSTA_BIAS;

    // Instruction decode
    always_comb
    begin
        op = OP_BAD;
        xx = '0;
        if (ins_reg == OPC_HLT)
            op = OP_HLT;
        else if (ins_reg >= BASE_ADD && ins_reg < BASE_SUB)
        begin
            op = OP_ADD;
            xx = 7'(ins_reg - BASE_ADD);
        end
        else if (ins_reg >= BASE_SUB && ins_reg < BASE_STA)
        begin
            op = OP_SUB;
            xx = 7'(ins_reg - BASE_SUB);
        end
        else if (ins_reg >= BASE_STA && ins_reg < BASE_LDI)
        begin
            op = OP_STA;
            xx = 7'(ins_reg - BASE_STA);
        end
        else if (ins_reg >= BASE_LDI && ins_reg < BASE_LDA)
        begin
            op = OP_LDI;
            xx = 7'(ins_reg - BASE_LDI);
        end
        else if (ins_reg >= BASE_LDA && ins_reg < BASE_BRA)
        begin
            op = OP_LDA;
            xx = 7'(ins_reg - BASE_LDA);
        end
        else if (ins_reg >= BASE_BRA && ins_reg < BASE_BRZ)
        begin
            op = OP_BRA;
            xx = 7'(ins_reg - BASE_BRA);
        end
        else if (ins_reg >= BASE_BRZ && ins_reg < BASE_BRP)
        begin
            op = OP_BRZ;
            xx = 7'(ins_reg - BASE_BRZ);
        end
        else if (ins_reg >= BASE_BRP && ins_reg < BASE_END)
        begin
            op = OP_BRP;
            xx = 7'(ins_reg - BASE_BRP);
        end
        else if (ins_reg == OPC_INP)   op = OP_INP;
        else if (ins_reg == OPC_OUT)   op = OP_OUT;
        else if (ins_reg == OPC_JAL)   op = OP_JAL;
        else if (ins_reg == OPC_RET)   op = OP_RET;
        else if (ins_reg == OPC_PUSH)  op = OP_PUSH;
        else if (ins_reg == OPC_POP)   op = OP_POP;
        else if (ins_reg == OPC_DUP)   op = OP_DUP;
        else if (ins_reg == OPC_DROP)  op = OP_DROP;
        else if (ins_reg == OPC_SWAP)  op = OP_SWAP;
        else if (ins_reg == OPC_RPUSH) op = OP_RPUSH;
        else if (ins_reg == OPC_RPOP)  op = OP_RPOP;
        else if (ins_reg == OPC_SADD)  op = OP_SADD;
        else if (ins_reg == OPC_SSUB)  op = OP_SSUB;
        else if (ins_reg == OPC_SMUL)  op = OP_SMUL;
        else if (ins_reg == OPC_SDIV)  op = OP_SDIV;
        else if (ins_reg == OPC_SMAX)  op = OP_SMAX;
        else if (ins_reg == OPC_SMIN)  op = OP_SMIN;
        else if (ins_reg == OPC_SGT)   op = OP_SGT;
        else if (ins_reg == OPC_SLT)   op = OP_SLT;
        else if (ins_reg == OPC_SNOT)  op = OP_SNOT;
        else if (ins_reg >= SPADD_LO && ins_reg <= SPADD_HI) op = OP_SPADD;
        else if (ins_reg >= SPSUB_LO && ins_reg <= SPSUB_HI) op = OP_SPSUB;
        else if (ins_reg >= SLDA_LO && ins_reg <= SLDA_HI)   op = OP_SLDA;
        else if (ins_reg >= SSTA_LO && ins_reg <= SSTA_HI)   op = OP_SSTA;
    end

    // Opcode and stack bound checks, all known before any operand is read
    always_comb
    begin
        dec_fault = 1'b0;
        dec_err   = ERR_STACK;
        unique case (op) inside
            OP_BAD:
            begin
                dec_fault = 1'b1;
                dec_err   = ERR_OPCODE;
            end
            OP_PUSH:
                dec_fault = (sp_c <= MID_C);
            OP_POP, OP_DROP, OP_SNOT:
                dec_fault = (sp_c > TOP_C);
            OP_DUP:
                dec_fault = (sp_c <= MID_C) || (sp_c > TOP_C);
            OP_SWAP, OP_SADD, OP_SSUB, OP_SMUL, OP_SDIV, OP_SMAX, OP_SMIN, OP_SGT, OP_SLT:
                dec_fault = (sp_c >= TOP_C);
            OP_RPUSH:
                dec_fault = (rsp_c >= TOP_C);
            OP_RPOP:
                dec_fault = (rsp_c < MID_C);
            OP_SPADD:
                dec_fault = (n_spadd > TOP1_C) || (n_spadd < MID_C);
            OP_SPSUB:
                dec_fault = (n_spsub > TOP1_C) || (n_spsub < MID_C);
            OP_SLDA:
                dec_fault = (idx_slda < MID_C) || (idx_slda > TOP_C) || (sp_c <= MID_C);
            OP_SSTA:
                dec_fault = (sp_c > TOP_C) || (idx_ssta < MID_C) || (idx_ssta > TOP_C);
            default:
                dec_fault = 1'b0;
        endcase
    end

    // Operand addresses: A is the top or the addressed word, B the one below the top
    always_comb
    begin
        unique case (op) inside
            OP_ADD, OP_SUB, OP_LDA: rda = to_idx(xx_c);
            OP_RPOP:                rda = to_idx(rsp_c);
            OP_SLDA:                rda = to_idx(idx_slda);
            default:                rda = to_idx(sp_c);
        endcase
    end
    assign rdb = to_idx(sp_c + ONE_C);

    // Binary stack ops: a is the top, b the one below
    assign b_val = mem_rdata;
    assign prod  = a_reg * b_val;

    always_comb
    begin
        unique case (op) inside
            OP_SADD: bin_r = cap999(sx24(a_reg) + sx24(b_val));
            OP_SSUB: bin_r = cap999(sx24(b_val) - sx24(a_reg));
            OP_SMUL: bin_r = cap999({{2{prod[21]}}, prod});
            OP_SMAX: bin_r = (a_reg > b_val) ? a_reg : b_val;
            OP_SMIN: bin_r = (a_reg < b_val) ? a_reg : b_val;
            OP_SGT:  bin_r = (b_val > a_reg) ? 11'sd1 : 11'sd0;
            default: bin_r = (b_val < a_reg) ? 11'sd1 : 11'sd0;
        endcase
    end

    // Execute: next register values, write data and write address
    always_comb
    begin
        acc_x  = acc_reg;
        pc_x   = pc_reg;
        ret_x  = ret_reg;
        sp_x   = sp_c;
        rsp_x  = rsp_c;
        emit_x = 1'b0;
        hlt_x  = 1'b0;
        res_x  = acc_reg;
        wad_x  = sp_c;
        unique case (op) inside
            OP_HLT: hlt_x = 1'b1;
            OP_ADD: acc_x = cap999(sx24(acc_reg) + sx24(a_reg));
            OP_SUB: acc_x = cap999(sx24(acc_reg) - sx24(a_reg));
            OP_STA: wad_x = xx_c;
            OP_LDI: acc_x = $signed({4'b0, xx});
            OP_LDA: acc_x = cap999(sx24(a_reg));
            OP_BRA: pc_x = $signed({4'b0, xx});
            OP_BRZ:
            begin
                if (acc_reg == 11'sd0)
                    pc_x = $signed({4'b0, xx});
            end
            OP_BRP:
            begin
                if (!acc_reg[10])
                    pc_x = $signed({4'b0, xx});
            end
            OP_INP: acc_x = cap999(sx24(word_reg));
            OP_OUT: emit_x = 1'b1;
            OP_JAL:
            begin
                ret_x = pc_reg;
                pc_x  = acc_reg;
            end
            OP_RET: pc_x = ret_reg;
            OP_PUSH:
            begin
                sp_x  = sp_c - ONE_C;
                wad_x = sp_c - ONE_C;
            end
            OP_POP:
            begin
                acc_x = cap999(sx24(a_reg));
                sp_x  = sp_c + ONE_C;
            end
            OP_DUP, OP_SLDA:
            begin
                sp_x  = sp_c - ONE_C;
                wad_x = sp_c - ONE_C;
                res_x = a_reg;
            end
            OP_DROP: sp_x = sp_c + ONE_C;
            OP_SWAP: res_x = b_val;
            OP_RPUSH:
            begin
                rsp_x = rsp_c + ONE_C;
                wad_x = rsp_c + ONE_C;
                res_x = ret_reg;
            end
            OP_RPOP:
            begin
                ret_x = a_reg;
                rsp_x = rsp_c - ONE_C;
            end
            OP_SADD, OP_SSUB, OP_SMUL, OP_SMAX, OP_SMIN, OP_SGT, OP_SLT:
            begin
                sp_x  = sp_c + ONE_C;
                wad_x = sp_c + ONE_C;
                res_x = bin_r;
            end
            OP_SDIV: wad_x = sp_c + ONE_C;
            OP_SNOT: res_x = (a_reg == 11'sd0) ? 11'sd1 : 11'sd0;
            OP_SPADD: sp_x = n_spadd;
            OP_SPSUB: sp_x = n_spsub;
            OP_SSTA:
            begin
                sp_x  = sp_c + ONE_C;
                wad_x = idx_ssta;
                res_x = a_reg;
            end
            default: hlt_x = 1'b0;
        endcase
    end

    sac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (b_val),
        .divisor  (a_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Memory port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        if (cmd.clr_step)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_reg;
        end
        else if (cmd.load)
        begin
            mem_we    = (load_c <= TOP_C);
            mem_addr  = to_idx(load_c);
            mem_wdata = word_reg;
        end
        else if (cmd.fetch)
        begin
            mem_re   = 1'b1;
            mem_addr = to_idx({{(CW-11){pc_reg[10]}}, pc_reg});
        end
        else if (cmd.rd_a)
        begin
            mem_re   = 1'b1;
            mem_addr = rda;
        end
        else if (cmd.rd_b)
        begin
            mem_re   = 1'b1;
            mem_addr = rdb;
        end
        else if (cmd.wr1)
        begin
            mem_we    = 1'b1;
            mem_addr  = wad_reg;
            mem_wdata = res_reg;
        end
        else if (cmd.wr2)
        begin
            mem_we    = 1'b1;
            mem_addr  = AW'(wad_reg + 1'b1);
            mem_wdata = a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_rdata <= mem[mem_addr];
    end

    // Architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pc_reg     <= '0;
            ret_reg    <= '0;
            sp_reg     <= SPW'(TOP_ADDRESS + 1);
            rsp_reg    <= SPW'(MIDDLE_ADDRESS - 1);
            halted_reg <= 1'b0;
            fault_reg  <= ERR_NONE;
            clr_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_reg <= AW'(clr_reg + 1'b1);
            if (cmd.latch_ins)
                pc_reg <= pc_reg + 11'sd1;
            if (cmd.set_fault)
            begin
                halted_reg <= 1'b1;
                fault_reg  <= cmd.fault_code;
            end
            if (cmd.exec)
            begin
                acc_reg <= acc_x;
                pc_reg  <= pc_x;
                ret_reg <= ret_x;
                sp_reg  <= sp_x[SPW-1:0];
                rsp_reg <= rsp_x[SPW-1:0];
                if (hlt_x)
                    halted_reg <= 1'b1;
            end
            if (cmd.div_load)
                sp_reg <= SPW'(sp_reg + 1'b1);
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= address;
            word_reg <= word_value;
            emit_reg <= 1'b0;
        end
        if (cmd.latch_ins)
            ins_reg <= mem_rdata;
        if (cmd.cap_a)
            a_reg <= mem_rdata;
        if (cmd.exec)
        begin
            res_reg  <= res_x;
            wad_reg  <= wad_x[AW-1:0];
            emit_reg <= emit_x;
        end
        if (cmd.div_load)
            res_reg <= cap999({{12{div_q[11]}}, div_q});
        if (cmd.resp_load)
        begin
            o_valid_reg  <= emit_reg;
            o_value_reg  <= emit_reg ? acc_reg : 11'sd0;
            o_halted_reg <= halted_reg;
            o_err_reg    <= fault_reg;
            o_pc_reg     <= pc_reg;
            o_acc_reg    <= acc_reg;
        end
    end

    assign sts.clr_last  = (clr_reg == AW'(TOP_ADDRESS));
    assign sts.in_mode   = mode;
    assign sts.halted    = halted_reg;
    assign sts.pc_bad    = pc_reg[10] || (pc_reg > 11'(TOP_ADDRESS));
    assign sts.dec_fault = dec_fault;
    assign sts.dec_err   = dec_err;
    assign sts.is_div    = (op == OP_SDIV);
    assign sts.div_zero  = (a_reg == 11'sd0);
    assign sts.div_done  = div_done;
    assign sts.has_wr1   = op inside {OP_STA, OP_PUSH, OP_DUP, OP_SWAP, OP_RPUSH, OP_SADD,
                                      OP_SSUB, OP_SMUL, OP_SMAX, OP_SMIN, OP_SGT, OP_SLT,
                                      OP_SNOT, OP_SLDA, OP_SSTA};
    assign sts.has_wr2   = (op == OP_SWAP);

    assign out_valid  = o_valid_reg;
    assign out_value  = o_value_reg;
    assign halted     = o_halted_reg;
    assign error_kind = o_err_reg;
    assign pc_now     = o_pc_reg;
    assign acc_now    = o_acc_reg;

endmodule

>>> hdl/sac_ctrl.sv
module sac_ctrl
    import sac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     res_valid,
    input  logic     res_stall,
    input  sac_sts_t sts,
    output sac_cmd_t cmd
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_LOAD   = 12'b0000_0000_0100,
        S_FETCH  = 12'b0000_0000_1000,
        S_DECODE = 12'b0000_0001_0000,
        S_READ_A = 12'b0000_0010_0000,
        S_READ_B = 12'b0000_0100_0000,
        S_EXEC   = 12'b0000_1000_0000,
        S_DIV    = 12'b0001_0000_0000,
        S_WRITE1 = 12'b0010_0000_0000,
        S_WRITE2 = 12'b0100_0000_0000,
        S_RESP   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;

    // Sequencer
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!sts.in_mode)
                        state_next = S_LOAD;
                    else if (sts.halted)
                        state_next = S_RESP;
                    else
                        state_next = S_FETCH;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_RESP;
            end
            S_FETCH:
            begin
                if (sts.pc_bad)
                begin
                    cmd.set_fault  = 1'b1;
                    cmd.fault_code = ERR_FETCH;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.latch_ins = 1'b1;
                state_next    = S_READ_A;
            end
            S_READ_A:
            begin
                if (sts.dec_fault)
                begin
                    cmd.set_fault  = 1'b1;
                    cmd.fault_code = sts.dec_err;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = S_READ_B;
                end
            end
            S_READ_B:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_b   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.is_div && sts.div_zero)
                begin
                    cmd.set_fault  = 1'b1;
                    cmd.fault_code = ERR_STACK;
                    state_next     = S_RESP;
                end
                else if (sts.is_div)
                begin
                    cmd.exec      = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = sts.has_wr1 ? S_WRITE1 : S_RESP;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_WRITE1;
                end
            end
            S_WRITE1:
            begin
                cmd.wr1    = 1'b1;
                state_next = sts.has_wr2 ? S_WRITE2 : S_RESP;
            end
            S_WRITE2:
            begin
                cmd.wr2    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Result valid holds while stalled
    always_comb
    begin
        if (cmd.resp_load)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

>>> hdl/sac_chk.sv
module sac_chk
    import sac_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               mode,
    input logic [7:0]         address,
    input logic signed [10:0] word_value,
    input logic               res_valid,
    input logic               res_stall,
    input logic               out_valid,
    input logic signed [10:0] out_value,
    input logic               halted,
    input logic [1:0]         error_kind,
    input logic signed [10:0] pc_now,
    input logic signed [10:0] acc_now
);

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(acc_now) && $stable(pc_now)
            && $stable(error_kind))
        else $error("stalled result changed");

    // A stalled request holds its payload
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(address)
            && $stable(word_value))
        else $error("stalled request changed");

    // Any error code comes with a halted machine
    a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (error_kind != ERR_NONE) |-> halted)
        else $error("error reported while running");

    // OUT value mirrors the accumulator, zero otherwise
    a_out_val: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (out_valid ? (out_value == acc_now) : (out_value == 11'sd0)))
        else $error("out_value mismatch");

    // One request at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request accepted while busy");

endmodule

bind stack_accumulator_cpu_core_top sac_chk u_chk (.*);
